FILE: hw/rtl/uart_rbp_pkg.sv
package uart_rbp_pkg;

  // Queue depths; each queue holds one byte less than its depth.
  localparam int RX_DEPTH = 16;
  localparam int TX_DEPTH = 16;
  localparam int RX_AW    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TX_AW    = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;

  // Request kinds carried on the input tuser.
  typedef enum logic [1:0] {
    REQ_PUSH     = 2'd0,
    REQ_POP      = 2'd1,
    REQ_LINE_RX  = 2'd2,
    REQ_TX_READY = 2'd3
  } req_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TX_FULL  = 2'd1,
    ST_RX_EMPTY = 2'd2,
    ST_RX_DROP  = 2'd3
  } status_t;

  // One access to the receive memory.
  typedef struct packed {
    logic             we;
    logic [RX_AW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [RX_AW-1:0] raddr;
  } rx_mem_t;

  // One access to the transmit memory.
  typedef struct packed {
    logic             we;
    logic [TX_AW-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [TX_AW-1:0] raddr;
  } tx_mem_t;

  // Result information known at the access cycle, before the read data returns.
  typedef struct packed {
    status_t status;
    logic    pop_ok;
    logic    tx_ok;
    logic    rx_waiting;
    logic    tx_irq;
  } req_info_t;

endpackage

FILE: hw/rtl/uart_rbp_ram.sv
module uart_rbp_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: hw/rtl/uart_rbp_ctrl.sv
module uart_rbp_ctrl import uart_rbp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  req_t       req,
  input  logic [7:0] byte_in,
  output rx_mem_t    rx_mem,
  output tx_mem_t    tx_mem,
  output req_info_t  info
);

  localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
  localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);

  logic [RX_AW-1:0] rx_wp, rx_rp, rx_wp_next, rx_rp_next, rx_wp_adv, rx_rp_adv;
  logic [TX_AW-1:0] tx_wp, tx_rp, tx_wp_next, tx_rp_next, tx_wp_adv, tx_rp_adv;
  logic             tx_irq, tx_irq_next;
  logic             rx_empty, rx_full, tx_empty, tx_full;

  // Pointer advance with wrap, and the empty and full tests.
  always_comb begin
    rx_wp_adv = (rx_wp == RX_LAST) ? '0 : rx_wp + 1'b1;
    rx_rp_adv = (rx_rp == RX_LAST) ? '0 : rx_rp + 1'b1;
    tx_wp_adv = (tx_wp == TX_LAST) ? '0 : tx_wp + 1'b1;
    tx_rp_adv = (tx_rp == TX_LAST) ? '0 : tx_rp + 1'b1;
    rx_empty  = (rx_wp == rx_rp);
    rx_full   = (rx_wp_adv == rx_rp);
    tx_empty  = (tx_wp == tx_rp);
    tx_full   = (tx_wp_adv == tx_rp);
  end

  // Request decode: memory accesses, pointer updates and result flags.
  always_comb begin
    rx_wp_next   = rx_wp;
    rx_rp_next   = rx_rp;
    tx_wp_next   = tx_wp;
    tx_rp_next   = tx_rp;
    tx_irq_next  = tx_irq;
    rx_mem       = '0;
    tx_mem       = '0;
    info         = '0;
    info.status  = ST_OK;
    rx_mem.waddr = rx_wp;
    rx_mem.wdata = byte_in;
    rx_mem.raddr = rx_rp;
    tx_mem.waddr = tx_wp;
    tx_mem.wdata = byte_in;
    tx_mem.raddr = tx_rp;
    unique case (req)
      REQ_PUSH: begin
        if (tx_full) begin
          info.status = ST_TX_FULL;
        end else begin
          tx_mem.we   = accept;
          tx_wp_next  = tx_wp_adv;
          tx_irq_next = 1'b1;
        end
      end
      REQ_POP: begin
        if (rx_empty) begin
          info.status = ST_RX_EMPTY;
        end else begin
          rx_mem.re   = accept;
          info.pop_ok = 1'b1;
          rx_rp_next  = rx_rp_adv;
        end
      end
      REQ_LINE_RX: begin
        if (rx_full) begin
          info.status = ST_RX_DROP;
        end else begin
          rx_mem.we  = accept;
          rx_wp_next = rx_wp_adv;
        end
      end
      REQ_TX_READY: begin
        if (!tx_empty) begin
          tx_mem.re  = accept;
          info.tx_ok = 1'b1;
          tx_rp_next = tx_rp_adv;
        end
        // The flag drops once the transmit queue is drained.
        if (tx_empty || (tx_rp_adv == tx_wp)) begin
          tx_irq_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
    info.rx_waiting = (rx_wp_next != rx_rp_next);
    info.tx_irq     = tx_irq_next;
  end

  // Apart from reset, pointer and flag registers change only on an accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_wp  <= '0;
      rx_rp  <= '0;
      tx_wp  <= '0;
      tx_rp  <= '0;
      tx_irq <= 1'b0;
    end else if (accept) begin
      rx_wp  <= rx_wp_next;
      rx_rp  <= rx_rp_next;
      tx_wp  <= tx_wp_next;
      tx_rp  <= tx_rp_next;
      tx_irq <= tx_irq_next;
    end
  end

endmodule

FILE: hw/rtl/uart_ring_buffer_pair_core.sv
// Receive and transmit byte queues, each kept in a RAM with a registered read port.
// A request passes the access stage, then the output register, to its result beat.
// Throughput: one request per cycle unless stalled; a pop or transmit-ready
// RAM read returns in the cycle after the pointer compare, pipelined behind it.
// Reset (rst, synchronous, active high) empties both queues, clears the
// transmit interrupt flag and drops any beat in flight; RAM contents are kept.
module uart_ring_buffer_pair_core import uart_rbp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // byte_in[7:0]
  input  logic [1:0]  s_tuser,   // req_type[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // status[1:0], read_byte[9:2], line_tx_byte[17:10],
                                 // line_tx_valid[18], rx_waiting[19],
                                 // tx_irq_enable[20], zero[23:21]
);

  rx_mem_t    rx_mem;
  tx_mem_t    tx_mem;
  req_info_t  info;
  req_info_t  p_info;
  logic       p_valid, p_move, accept;
  logic [7:0] rx_rdata, tx_rdata;

  logic       o_valid;
  status_t    o_status;
  logic [7:0] o_read_byte, o_tx_byte;
  logic       o_tx_valid, o_rx_waiting, o_tx_irq;

  // Handshake: the access stage drains into the output register.
  assign p_move   = p_valid && (!o_valid || m_tready);
  assign s_tready = !p_valid || p_move;
  assign accept   = s_tvalid && s_tready;

  uart_rbp_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .req     (req_t'(s_tuser)),
    .byte_in (s_tdata),
    .rx_mem  (rx_mem),
    .tx_mem  (tx_mem),
    .info    (info)
  );

  uart_rbp_ram #(.DEPTH(RX_DEPTH), .WIDTH(8)) u_rx_ram (
    .clk   (clk),
    .we    (rx_mem.we),
    .waddr (rx_mem.waddr),
    .wdata (rx_mem.wdata),
    .re    (rx_mem.re),
    .raddr (rx_mem.raddr),
    .rdata (rx_rdata)
  );

  uart_rbp_ram #(.DEPTH(TX_DEPTH), .WIDTH(8)) u_tx_ram (
    .clk   (clk),
    .we    (tx_mem.we),
    .waddr (tx_mem.waddr),
    .wdata (tx_mem.wdata),
    .re    (tx_mem.re),
    .raddr (tx_mem.raddr),
    .rdata (tx_rdata)
  );

  // Access stage: holds the request while its RAM read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (accept) begin
      p_valid <= 1'b1;
    end else if (p_move) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_info <= info;
    end
  end

  // Output register: merges the read data with the status flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (p_move) begin
      o_valid <= 1'b1;
    end else if (m_tready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (p_move) begin
      o_status     <= p_info.status;
      o_read_byte  <= p_info.pop_ok ? rx_rdata : 8'd0;
      o_tx_byte    <= p_info.tx_ok ? tx_rdata : 8'd0;
      o_tx_valid   <= p_info.tx_ok;
      o_rx_waiting <= p_info.rx_waiting;
      o_tx_irq     <= p_info.tx_irq;
    end
  end

  assign m_tvalid = o_valid;
  assign m_tdata  = {3'b000, o_tx_irq, o_rx_waiting, o_tx_valid,
                     o_tx_byte, o_read_byte, o_status};

`ifndef ASSERT_OFF
  // Reset leaves nothing in flight.
  a_reset_empty: assert property (@(posedge clk) rst |=> !p_valid && !o_valid)
    else $error("beat in flight after reset");

  // A staged request is never lost while the output is stalled.
  a_stage_held: assert property (@(posedge clk) disable iff (rst)
    (p_valid && !p_move) |=> p_valid)
    else $error("staged request dropped");

  // A byte handed to the transmitter always comes with an ok status.
  a_tx_ok: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_tx_valid) |-> (o_status == ST_OK))
    else $error("transmit byte with error status");

  // A successful pop launches a receive RAM read on the accepted beat.
  a_pop_read: assert property (@(posedge clk) disable iff (rst)
    (accept && info.pop_ok) |-> rx_mem.re)
    else $error("pop without receive read");
`endif

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import uart_rbp_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 8;

  // One result beat, laid out as on m_tdata from the top bit down.
  typedef struct packed {
    logic [2:0]  pad;
    logic        tx_irq;
    logic        rx_wait;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic [7:0]  rd_byte;
    status_t     status;
  } uart_reply_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // byte_in[7:0]
  logic [1:0]  s_tuser = '0;   // req_type[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // status, read_byte, line_tx_byte, line_tx_valid,
                               // rx_waiting, tx_irq_enable, zero fill

  // Shadow copy of both queues and the interrupt flag.
  logic [7:0]  rx_mem [RX_DEPTH];
  logic [7:0]  tx_mem [TX_DEPTH];
  int unsigned rx_wr = 0;
  int unsigned rx_rd = 0;
  int unsigned tx_wr = 0;
  int unsigned tx_rd = 0;
  logic        irq_flag = 1'b0;

  uart_reply_t awaited_replies[$];
  int          fails = 0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;

  uart_ring_buffer_pair_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  // Ring pointer step with wrap at the queue depth.
  function automatic int unsigned next_slot(int unsigned p, int unsigned depth);
    return (p >= depth - 1) ? 0 : p + 1;
  endfunction

  // Applies one request to the shadow queues and returns the reply it causes.
  function automatic uart_reply_t service_request(req_t kind, logic [7:0] data);
    uart_reply_t r;
    int unsigned nxt;
    r = '0;
    r.status = ST_OK;
    case (kind)
      REQ_PUSH: begin
        nxt = next_slot(tx_wr, TX_DEPTH);
        if (nxt == tx_rd) begin
          r.status = ST_TX_FULL;
        end else begin
          tx_mem[tx_wr] = data;
          tx_wr = nxt;
          irq_flag = 1'b1;
        end
      end
      REQ_POP: begin
        if (rx_wr == rx_rd) begin
          r.status = ST_RX_EMPTY;
        end else begin
          r.rd_byte = rx_mem[rx_rd];
          rx_rd = next_slot(rx_rd, RX_DEPTH);
        end
      end
      REQ_LINE_RX: begin
        nxt = next_slot(rx_wr, RX_DEPTH);
        if (nxt == rx_rd) begin
          r.status = ST_RX_DROP;
        end else begin
          rx_mem[rx_wr] = data;
          rx_wr = nxt;
        end
      end
      default: begin
        if (tx_wr != tx_rd) begin
          r.tx_byte = tx_mem[tx_rd];
          r.tx_valid = 1'b1;
          tx_rd = next_slot(tx_rd, TX_DEPTH);
        end
        // The flag drops whenever the transmit queue ends up empty.
        if (tx_rd == tx_wr) begin
          irq_flag = 1'b0;
        end
      end
    endcase
    r.rx_wait = (rx_wr != rx_rd);
    r.tx_irq = irq_flag;
    return r;
  endfunction

  // Compares one result beat with the oldest reply still awaited.
  task automatic check_reply(uart_reply_t got);
    uart_reply_t want;
    if (awaited_replies.size() == 0) begin
      $error("unexpected result beat: %h", got);
      fails++;
    end else begin
      want = awaited_replies.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        fails++;
      end
      if (got.rd_byte !== want.rd_byte) begin
        $error("read_byte: expected %h, actual %h", want.rd_byte, got.rd_byte);
        fails++;
      end
      if (got.tx_byte !== want.tx_byte) begin
        $error("line_tx_byte: expected %h, actual %h", want.tx_byte, got.tx_byte);
        fails++;
      end
      if (got.tx_valid !== want.tx_valid) begin
        $error("line_tx_valid: expected %b, actual %b", want.tx_valid, got.tx_valid);
        fails++;
      end
      if (got.rx_wait !== want.rx_wait) begin
        $error("rx_waiting: expected %b, actual %b", want.rx_wait, got.rx_wait);
        fails++;
      end
      if (got.tx_irq !== want.tx_irq) begin
        $error("tx_irq_enable: expected %b, actual %b", want.tx_irq, got.tx_irq);
        fails++;
      end
      if (got.pad !== want.pad) begin
        $error("zero fill: expected %b, actual %b", want.pad, got.pad);
        fails++;
      end
    end
  endtask

  // Result beats are checked before the request beat of the same edge is predicted.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        check_reply(uart_reply_t'(m_tdata));
      end
      if (s_tvalid && s_tready) begin
        awaited_replies.push_back(service_request(req_t'(s_tuser), s_tdata));
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Ends a hung run: counts edges at which neither side moves a beat.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Offers one request beat, waits for it to be taken, then may go idle.
  task automatic send_beat(req_t kind, logic [7:0] data);
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Empty-queue refusals, byte extremes, draining and the interrupt flag.
  task automatic test_directed_corners();
    idle_pct = 0;
    stall_pct = 0;
    send_beat(REQ_POP, 8'hA5);
    send_beat(REQ_TX_READY, 8'hFF);
    send_beat(REQ_PUSH, 8'h00);
    send_beat(REQ_PUSH, 8'hFF);
    send_beat(REQ_PUSH, 8'h5A);
    send_beat(REQ_TX_READY, 8'h00);
    send_beat(REQ_TX_READY, 8'h00);
    send_beat(REQ_TX_READY, 8'hFF);
    send_beat(REQ_TX_READY, 8'h00);
    send_beat(REQ_LINE_RX, 8'h00);
    send_beat(REQ_LINE_RX, 8'hFF);
    send_beat(REQ_LINE_RX, 8'h3C);
    send_beat(REQ_POP, 8'hFF);
    send_beat(REQ_POP, 8'h00);
    send_beat(REQ_POP, 8'h00);
    send_beat(REQ_POP, 8'h00);
    send_beat(REQ_PUSH, 8'hC3);
    send_beat(REQ_TX_READY, 8'h00);
  endtask

  // Bursts that lean toward one request kind, so queues fill up and run dry.
  task automatic test_burst_traffic(int items, int idle, int stall);
    int   sent;
    int   len;
    req_t lean;
    req_t kind;
    idle_pct = idle;
    stall_pct = stall;
    sent = 0;
    while (sent < items) begin
      lean = req_t'($urandom_range(3));
      len = $urandom_range(32, 4);
      repeat (len) begin
        kind = ($urandom_range(99) < 65) ? lean : req_t'($urandom_range(3));
        send_beat(kind, 8'($urandom_range(255)));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_corners();
    test_burst_traffic(175, 0, 0);
    test_burst_traffic(175, 73, 0);
    test_burst_traffic(175, 0, 73);
    test_burst_traffic(175, 16, 16);
    s_tvalid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/uart_rbp_pkg.sv
hw/rtl/uart_rbp_ram.sv
hw/rtl/uart_rbp_ctrl.sv
hw/rtl/uart_ring_buffer_pair_core.sv
test/tb_top.sv
